### design/pfm_pkg.sv
// Package for the power channel fault monitor: widths, register indexes,
// reset values and pipeline stage types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  localparam int CHANNELS   = 32;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W       = 5;
  localparam int VAL_W      = 16;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int CMP_W      = VAL_W + 2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POWER_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_MASK = 2'd2;

  localparam logic [VAL_W-1:0]      POWER_STEP_RST   = 16'd1000;
  localparam logic [VAL_W-1:0]      VOLTAGE_STEP_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] DISABLE_MASK_RST = 32'h0001_ffff;
  localparam logic [VAL_W-1:0]      CURRENT_LIM_RST  = 16'd1000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LIMIT  = 1'b1;

  typedef logic signed [VAL_W-1:0]  sval_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic            vld;
    logic            op;
    logic            in_range;
    logic            primed;
    logic            on_both;
    logic [CH_W-1:0] ch;
    sval_t           p;
    sval_t           v;
    sval_t           c;
    sval_t           lp;
    sval_t           lv;
    logic [VAL_W-1:0] lim;
  } stage_a_t;

  typedef struct packed {
    logic            vld;
    logic            op;
    logic            elig;
    logic [CH_W-1:0] ch;
    diff_t           dp;
    diff_t           dv;
    logic            cur_over;
  } stage_b_t;

  typedef struct packed {
    logic            vld;
    logic            op;
    logic            elig;
    logic [CH_W-1:0] ch;
    logic            trip;
  } stage_c_t;

endpackage

`default_nettype wire

### design/power_channel_fault_monitor.sv
// Power channel fault monitor top level: per-channel state, three-stage
// trip pipeline and configuration registers.
// Depends on pfm_pkg.
//
// Usage:
//   in_*  : sample or limit-write transactions. in_tuser is the op
//           (0 sample, 1 current-limit write). One per cycle if in_tready.
//   out_* : exactly one result per input transaction, in order.
//   cfg_* : register writes (index 0 power step, 1 voltage step,
//           2 disableable mask); cfg_ready is always high. Write only while
//           the pipeline is empty.
//   A transaction passes through the stage A, B and C registers in turn;
//   out_tvalid is the valid bit of stage C. Throughput is one
//   transaction per cycle while the receiver does not stall, set by the
//   read-modify-write of the per-channel register file at the input stage.
//   Reset clears the pipeline, the on and primed bits, loads every current
//   limit with 1000 and the registers with their defaults.
//   When the receiver stalls, the whole pipeline holds and in_tready drops
//   once the output register is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module power_channel_fault_monitor (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // channel[4:0] power[20:5] voltage[36:21] current[52:37]
  // channel_on[53] new_limit[69:54] zero[71:70]
  input  wire  [pfm_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[0]
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // trip[0] trip_channel[5:1] zero[7:6]
  output logic [pfm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfm_pkg::*;

  logic [VAL_W-1:0]      power_step_r;
  logic [VAL_W-1:0]      voltage_step_r;
  logic [CFG_DATA_W-1:0] disable_mask_r;

  logic [VAL_W-1:0] last_power_r   [CHANNELS];
  logic [VAL_W-1:0] last_voltage_r [CHANNELS];
  logic [VAL_W-1:0] cur_lim_r      [CHANNELS];
  logic [CHANNELS-1:0] last_on_r;
  logic [CHANNELS-1:0] primed_r;

  stage_a_t sa_r, sa_nxt;
  stage_b_t sb_r, sb_nxt;
  stage_c_t sc_r, sc_nxt;

  logic                advance;
  logic                accept;
  logic [CH_W-1:0]     in_ch;
  logic [CH_IDX_W-1:0] idx;
  logic                in_range;
  logic                in_on;

  assign advance   = !sc_r.vld || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_ch    = in_tdata[4:0];
  assign in_on    = in_tdata[53];
  assign idx      = in_ch[CH_IDX_W-1:0];
  assign in_range = (32'(in_ch) < 32'(CHANNELS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_step_r   <= POWER_STEP_RST;
      voltage_step_r <= VOLTAGE_STEP_RST;
      disable_mask_r <= DISABLE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER_STEP:   power_step_r   <= cfg_data[VAL_W-1:0];
        REG_VOLTAGE_STEP: voltage_step_r <= cfg_data[VAL_W-1:0];
        REG_DISABLE_MASK: disable_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-channel state: read and update at the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_on_r <= '0;
      primed_r  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_lim_r[i] <= CURRENT_LIM_RST;
      end
    end else if (accept && in_range) begin
      if (in_tuser == OP_LIMIT) begin
        cur_lim_r[idx] <= in_tdata[69:54];
      end else begin
        last_on_r[idx] <= in_on;
        primed_r[idx]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range && in_tuser == OP_SAMPLE) begin
      last_power_r[idx]   <= in_tdata[20:5];
      last_voltage_r[idx] <= in_tdata[36:21];
    end
  end

  // stage A: capture sample and stored state
  always_comb begin
    sa_nxt          = sa_r;
    sa_nxt.vld      = accept;
    sa_nxt.op       = in_tuser;
    sa_nxt.in_range = in_range;
    sa_nxt.primed   = primed_r[idx];
    sa_nxt.on_both  = in_on && last_on_r[idx];
    sa_nxt.ch       = in_ch;
    sa_nxt.p        = sval_t'(in_tdata[20:5]);
    sa_nxt.v        = sval_t'(in_tdata[36:21]);
    sa_nxt.c        = sval_t'(in_tdata[52:37]);
    sa_nxt.lp       = sval_t'(last_power_r[idx]);
    sa_nxt.lv       = sval_t'(last_voltage_r[idx]);
    sa_nxt.lim      = cur_lim_r[idx];
  end

  // stage B: steps and current compare
  always_comb begin
    sb_nxt          = sb_r;
    sb_nxt.vld      = sa_r.vld;
    sb_nxt.op       = sa_r.op;
    sb_nxt.ch       = sa_r.ch;
    sb_nxt.elig     = sa_r.in_range && (sa_r.op == OP_SAMPLE) && sa_r.primed
                      && sa_r.on_both && disable_mask_r[sa_r.ch];
    sb_nxt.dp       = DIFF_W'(sa_r.p) - DIFF_W'(sa_r.lp);
    sb_nxt.dv       = DIFF_W'(sa_r.v) - DIFF_W'(sa_r.lv);
    sb_nxt.cur_over = $signed(DIFF_W'(sa_r.c)) > $signed({1'b0, sa_r.lim});
  end

  // stage C: step limits and trip decision
  logic signed [CMP_W-1:0] dp_x, dv_x, plim_x, vlim_x;
  logic                    p_exc, v_exc;

  always_comb begin
    dp_x   = CMP_W'(sb_r.dp);
    dv_x   = CMP_W'(sb_r.dv);
    plim_x = $signed({2'b00, power_step_r});
    vlim_x = $signed({2'b00, voltage_step_r});
    p_exc  = (dp_x > plim_x) || (dp_x < -plim_x);
    v_exc  = (dv_x > vlim_x) || (dv_x < -vlim_x);
    sc_nxt      = sc_r;
    sc_nxt.vld  = sb_r.vld;
    sc_nxt.op   = sb_r.op;
    sc_nxt.elig = sb_r.elig;
    sc_nxt.ch   = sb_r.ch;
    sc_nxt.trip = sb_r.elig && (p_exc || v_exc || sb_r.cur_over);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.vld <= 1'b0;
      sb_r.vld <= 1'b0;
      sc_r.vld <= 1'b0;
    end else if (advance) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      sc_r <= sc_nxt;
    end
  end

  assign out_tvalid = sc_r.vld;
  assign out_tdata  = {2'b00, sc_r.ch, sc_r.trip};

`ifndef SYNTH
  a_limit_no_trip: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r.vld && sc_r.op == OP_LIMIT |-> !sc_r.trip)
    else $error("limit write produced a trip");

  a_inelig_no_trip: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r.vld && !sc_r.elig |-> !sc_r.trip)
    else $error("trip on ineligible sample");

  a_primed_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_range && in_tuser == OP_SAMPLE |=> primed_r[$past(idx)])
    else $error("sample did not prime its channel");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(sb_r.vld) && $stable(sb_r.ch) && $stable(sb_r.elig)
      && $stable(sb_r.cur_over) && $stable(sc_r))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

### tb/power_channel_fault_monitor_tb.sv
// Self-checking testbench for power_channel_fault_monitor: directed and random
// sample and limit-write traffic with random stalls on both streams.
// Depends on pfm_pkg and the power_channel_fault_monitor RTL.
`timescale 1ns / 1ps

module power_channel_fault_monitor_tb;
  import pfm_pkg::*;

  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    logic             op;
    logic [CH_W-1:0]  ch;
    sval_t            pw;
    sval_t            vt;
    sval_t            cur;
    logic             on;
    logic [VAL_W-1:0] lim;
  } sample_t;

  typedef struct {
    logic            trip;
    logic [CH_W-1:0] ch;
  } trip_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's state and registers
  logic [VAL_W-1:0]      pwr_step;
  logic [VAL_W-1:0]      volt_step;
  logic [CFG_DATA_W-1:0] dis_mask;
  sval_t                 last_pw  [CHANNELS];
  sval_t                 last_vt  [CHANNELS];
  logic                  last_on  [CHANNELS];
  logic                  primed   [CHANNELS];
  logic [VAL_W-1:0]      cur_lim  [CHANNELS];

  trip_t trip_q[$];
  bit    tx_idle_en = 1'b1;
  bit    rx_idle_en = 1'b1;
  int    err_count = 0;
  int    n_items = 0;
  int    n_limits = 0;
  int    n_trips = 0;
  int    n_cfg = 0;
  int    cycle_cnt = 0;

  power_channel_fault_monitor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("power_channel_fault_monitor_tb: done, errors");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    trip_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (trip_q.size() == 0) begin
          $error("result with no expectation: tdata %h", out_tdata);
          err_count++;
        end else begin
          want = trip_q.pop_front();
          if (want.trip) n_trips++;
          if (out_tdata[0] !== want.trip) begin
            $error("trip: expected %0b, actual %0b", want.trip, out_tdata[0]);
            err_count++;
          end
          if (out_tdata[5:1] !== want.ch) begin
            $error("trip_channel: expected %0d, actual %0d", want.ch, out_tdata[5:1]);
            err_count++;
          end
        end
      end
      out_tready <= !(rx_idle_en && $urandom_range(0, 99) < 27);
    end
  end

  function automatic logic predict_trip(input sample_t s);
    int   dp;
    int   dv;
    logic gate;
    logic cause;
    logic trip;
    trip = 1'b0;
    if (s.op == OP_LIMIT) begin
      cur_lim[s.ch] = s.lim;
    end else begin
      if (primed[s.ch]) begin
        dp = int'(s.pw) - int'(last_pw[s.ch]);
        dv = int'(s.vt) - int'(last_vt[s.ch]);
        gate = s.on && last_on[s.ch] && dis_mask[s.ch];
        cause = dp > int'(pwr_step) || dp < -int'(pwr_step) ||
                dv > int'(volt_step) || dv < -int'(volt_step) ||
                int'(s.cur) > int'(cur_lim[s.ch]);
        trip = gate && cause;
      end
      last_pw[s.ch] = s.pw;
      last_vt[s.ch] = s.vt;
      last_on[s.ch] = s.on;
      primed[s.ch]  = 1'b1;
    end
    return trip;
  endfunction

  task automatic send_item(input sample_t s);
    trip_t r;
    while (tx_idle_en && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.op;
    in_tdata  <= {2'b00, s.lim, s.on, s.cur, s.vt, s.pw, s.ch};
    do @(posedge clk); while (!in_tready);
    r.trip = predict_trip(s);
    r.ch   = s.ch;
    trip_q.push_back(r);
    n_items++;
    if (s.op == OP_LIMIT) n_limits++;
  endtask

  task automatic send_sample(input int ch, input int pw, input int vt, input int cur,
                             input logic on);
    sample_t s;
    s.op  = OP_SAMPLE;
    s.ch  = ch[CH_W-1:0];
    s.pw  = pw[VAL_W-1:0];
    s.vt  = vt[VAL_W-1:0];
    s.cur = cur[VAL_W-1:0];
    s.on  = on;
    s.lim = 16'($urandom());
    send_item(s);
  endtask

  task automatic send_limit(input int ch, input logic [VAL_W-1:0] lim);
    sample_t s;
    s.op  = OP_LIMIT;
    s.ch  = ch[CH_W-1:0];
    s.pw  = 16'($urandom());
    s.vt  = 16'($urandom());
    s.cur = 16'($urandom());
    s.on  = 1'($urandom());
    s.lim = lim;
    send_item(s);
  endtask

  // hold the input until every result is back, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (trip_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_apply(input logic [VAL_W-1:0] ps, input logic [VAL_W-1:0] vs,
                           input logic [CFG_DATA_W-1:0] mask);
    cfg_beat(REG_POWER_STEP, {16'h0000, ps});
    cfg_beat(REG_VOLTAGE_STEP, {16'h0000, vs});
    cfg_beat(REG_DISABLE_MASK, mask);
    cfg_valid <= 1'b0;
    pwr_step  = ps;
    volt_step = vs;
    dis_mask  = mask;
    n_cfg++;
  endtask

  function automatic int near_step(input logic [VAL_W-1:0] lim);
    int mag;
    case ($urandom_range(0, 3))
      0: mag = int'(lim) + int'($urandom_range(0, 2)) - 1;
      1: mag = int'($urandom_range(0, lim));
      2: mag = 0;
      default: mag = int'($urandom_range(0, int'(lim) + 300));
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  task automatic send_random_item();
    sample_t s;
    int      r;
    int      pick;
    r = $urandom_range(0, 99);
    s.op  = OP_SAMPLE;
    s.ch  = CH_W'($urandom_range(0, CHANNELS - 1));
    s.pw  = 16'($urandom());
    s.vt  = 16'($urandom());
    s.cur = 16'($urandom());
    s.on  = 1'($urandom());
    s.lim = 16'($urandom());
    if (r < 8) begin
      s.op = OP_LIMIT;
      if ($urandom_range(0, 1) != 0) s.lim = 16'($urandom_range(0, 2000));
    end else if (r >= 18) begin
      s.pw = 16'(int'(last_pw[s.ch]) + near_step(pwr_step));
      s.vt = 16'(int'(last_vt[s.ch]) + near_step(volt_step));
      pick = $urandom_range(0, 9);
      if (pick < 7) s.cur = 16'($urandom_range(0, cur_lim[s.ch]));
      else if (pick < 9) s.cur = 16'(int'(cur_lim[s.ch]) + int'($urandom_range(0, 2)) - 1);
      s.on = ($urandom_range(0, 9) != 0);
    end
    send_item(s);
  endtask

  task automatic test_reset_defaults();
    send_sample(0, 0, 0, 0, 1'b1);
    send_sample(0, 1000, 0, 0, 1'b1);
    send_sample(0, -1, 0, 0, 1'b1);
    send_sample(0, -1, 1001, 0, 1'b1);
    send_sample(0, -1, 1001, 1000, 1'b1);
    send_sample(0, -1, 1001, 1001, 1'b1);
    send_sample(0, -1, 1001, -32768, 1'b1);
    send_sample(0, -1, 1001, 1001, 1'b0);
    send_sample(0, -1, 1001, 1001, 1'b1);
    send_sample(2, 0, 0, 32767, 1'b1);
    send_sample(17, -32768, -32768, 0, 1'b1);
    send_sample(17, 32767, 32767, 32767, 1'b1);
    send_sample(16, -32768, 32767, 0, 1'b1);
    send_sample(16, 32767, -32768, 0, 1'b1);
    send_limit(16, 16'h0000);
    send_sample(16, 32767, -32768, 1, 1'b1);
    send_sample(16, 32767, -32768, 0, 1'b1);
    send_limit(16, 16'hffff);
    send_sample(16, 32767, -32768, 32767, 1'b1);
    send_limit(31, 16'haaaa);
    send_limit(1, 16'h5555);
    send_sample(31, 0, 0, 0, 1'b0);
  endtask

  task automatic test_step_extremes();
    settle();
    cfg_apply(16'h0000, 16'h0000, 32'hffff_ffff);
    send_sample(20, 0, 0, 0, 1'b1);
    send_sample(20, 0, 0, 0, 1'b1);
    send_sample(20, 1, 0, 0, 1'b1);
    send_sample(20, 1, -1, 0, 1'b1);
    send_sample(30, 5, 5, 1001, 1'b1);
    send_sample(30, 5, 5, 1001, 1'b1);
    settle();
    cfg_apply(16'hffff, 16'hffff, 32'hffff_ffff);
    send_sample(21, -32768, -32768, 0, 1'b1);
    send_sample(21, 32767, 32767, 0, 1'b1);
    send_sample(21, -32768, -32768, 1001, 1'b1);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: cfg_apply(16'h0000, 16'h0000, 32'hffff_ffff);
        1: cfg_apply(16'hffff, 16'hffff, $urandom());
        5: cfg_apply(16'($urandom()), 16'($urandom()), $urandom());
        default: cfg_apply(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                           $urandom());
      endcase
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  initial begin
    pwr_step  = POWER_STEP_RST;
    volt_step = VOLTAGE_STEP_RST;
    dis_mask  = DISABLE_MASK_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      last_pw[i] = '0;
      last_vt[i] = '0;
      last_on[i] = 1'b0;
      primed[i]  = 1'b0;
      cur_lim[i] = CURRENT_LIM_RST;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_step_extremes();
    test_random_traffic();
    settle();
    $display("run covered %0d transactions (%0d limit writes) over %0d register settings,",
             n_items, n_limits, n_cfg);
    $display("with %0d trips reported", n_trips);
    if (err_count == 0) begin
      $display("power_channel_fault_monitor_tb: done, clean");
    end else begin
      $display("power_channel_fault_monitor_tb: done, errors");
    end
    $finish;
  end

endmodule

### power_channel_fault_monitor.f
design/pfm_pkg.sv
design/power_channel_fault_monitor.sv
tb/power_channel_fault_monitor_tb.sv
